@@ sv/olst_pkg.sv @@
// shared types and codes for the ordered list store
package olst_pkg;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 7;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_HEAD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // broadcast command from the control logic to every cell
    typedef struct packed {
        logic               insert;
        logic               remove;
        logic               search;
        logic [VALUE_W-1:0] value;
    } olst_cmd_t;

endpackage

@@ sv/ordered_list_store.sv @@
// top level of the ordered list store: control, cell chain and result register
//
// A bounded ordered list of signed 32-bit values held in a chain of DEPTH cells.
// Each input transfer carries an action (append, insert at head, insert at a
// position, remove at a position, search) and produces exactly one result transfer
// with found, status and the new count. Inserts and removes shift the cells from
// the given position on with their neighbors in the cycle the item is accepted; a
// search compares all held cells in that same cycle and registers one hit bit per
// cell, held until the next search. The hit bits are ORed into the result register
// when the middle stage moves on to it, which can stall while the result side does
// not take transfers. A new item is accepted every cycle while the result side
// takes transfers. The OR over DEPTH hit bits sets the clock limit of the second
// stage. Entries are not cleared at reset; only entries below the count take part
// in a search.
module ordered_list_store
    import olst_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ACTION_W-1:0]   s_action,
    input  logic [POSITION_W-1:0] s_position,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [STATUS_W-1:0]   m_status,
    output logic [COUNT_W-1:0]    m_count
);

    // occupancy counts 0 to DEPTH
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing the position field with occupancy
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control state
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    logic                pend_reg;
    logic                m_valid_reg;

    // payload of the middle stage and of the result register
    logic [STATUS_W-1:0] pend_status_reg;
    logic [COUNT_W-1:0]  pend_count_reg;
    logic                pend_search_reg;
    logic                m_found_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                accept;
    logic                out_free;
    logic                full;
    logic [CMP_W-1:0]    pos_cmp;
    logic [CMP_W-1:0]    occ_cmp;
    logic [CMP_W-1:0]    occ_next_ext;
    logic [CNT_W-1:0]    cell_pos;
    logic [STATUS_W-1:0] status_next;
    olst_cmd_t           cmd;

    logic [VALUE_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]    cell_hit;

    // result slot frees when empty or when its transfer completes this cycle
    assign out_free = !m_valid_reg || m_ready;
    // middle stage may take a new item when empty or when it moves on now
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign full    = (occ_reg == FULL_CNT);
    assign pos_cmp = CMP_W'(s_position);
    assign occ_cmp = CMP_W'(occ_reg);

    // decode the action against the current count
    always_comb begin
        cmd.insert  = 1'b0;
        cmd.remove  = 1'b0;
        cmd.search  = 1'b0;
        cmd.value   = s_value;
        cell_pos    = occ_reg;
        status_next = ST_OK;
        occ_next    = occ_reg;
        case (s_action)
            ACT_APPEND: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.insert = 1'b1;
                    cell_pos   = occ_reg;
                end
            end
            ACT_HEAD: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.insert = 1'b1;
                    cell_pos   = '0;
                end
            end
            ACT_INSERT: begin
                // range check goes before the full check
                if (pos_cmp > occ_cmp) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.insert = 1'b1;
                    cell_pos   = CNT_W'(s_position);
                end
            end
            ACT_REMOVE: begin
                if (pos_cmp >= occ_cmp) begin
                    status_next = ST_RANGE;
                end else begin
                    cmd.remove = 1'b1;
                    cell_pos   = CNT_W'(s_position);
                end
            end
            ACT_SEARCH: begin
                cmd.search = 1'b1;
            end
            default: begin
                // unused actions change nothing
            end
        endcase
        if (cmd.insert) begin
            occ_next = occ_reg + CNT_W'(1);
        end else if (cmd.remove) begin
            occ_next = occ_reg - CNT_W'(1);
        end
        // cells act only on an accepted transfer
        if (!accept) begin
            cmd.insert = 1'b0;
            cmd.remove = 1'b0;
            cmd.search = 1'b0;
        end
    end

    assign occ_next_ext = CMP_W'(occ_next);

    // chain of cells, each fed by its left and right neighbor; the first cell takes the input value on the left
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = s_value;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        olst_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .pos        (cell_pos),
            .occ        (occ_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                occ_reg <= occ_next;
            end
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= pend_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg <= status_next;
            pend_count_reg  <= occ_next_ext[COUNT_W-1:0];
            pend_search_reg <= cmd.search;
        end
        if (pend_reg && out_free) begin
            m_found_reg  <= pend_search_reg && (|cell_hit);
            m_status_reg <= pend_status_reg;
            m_count_reg  <= pend_count_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    // count never passes the number of cells
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= FULL_CNT)
        else $error("occupancy above depth");

    // a dropped append leaves the count alone
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && s_action == ACT_APPEND) |=> $stable(occ_reg))
        else $error("count changed on a full append");

    // an item in the middle stage reaches the result register when it is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && out_free) |=> m_valid_reg)
        else $error("pending result lost");

    // found is raised only by a search
    a_found_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && out_free && !pend_search_reg) |=> !m_found_reg)
        else $error("found set outside search");

endmodule

@@ sv/olst_cell.sv @@
// one storage cell of the list: holds an entry, shifts with its neighbors, compares
module olst_cell
    import olst_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic               aclk,
    input  olst_cmd_t          cmd,
    input  logic [CNT_W-1:0]   pos,
    input  logic [CNT_W-1:0]   occ,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    output logic [VALUE_W-1:0] data,
    output logic               hit
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               hit_reg;
    logic               hit_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert) begin
            if (IDX == pos) begin
                entry_next = cmd.value;
            end else if (IDX > pos) begin
                entry_next = left_data;
            end
        end else if (cmd.remove) begin
            if (IDX >= pos) begin
                entry_next = right_data;
            end
        end
    end

    // only held entries take part in a search
    assign hit_next = cmd.search && (IDX < occ) && (entry_reg == cmd.value);

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        // hit bit holds until the next search so a stalled result keeps it
        if (cmd.search) begin
            hit_reg <= hit_next;
        end
    end

    assign data = entry_reg;
    assign hit  = hit_reg;

endmodule
